// ----- src/tbbs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbbs_pkg
// Shared types and constants of the token budget batch scheduler.
// ----------------------------------------------------------------------------
package tbbs_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int SLOT_W     = 4;
  localparam int SLOT_SPACE = 2 ** SLOT_W;
  localparam int PH_W       = 2;
  localparam int CNT_W      = 16;
  localparam int RR_W       = 4;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 16;

  localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PH_W-1:0] PH_PREFILL = 2'd1;
  localparam logic [PH_W-1:0] PH_DECODE  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SCHED = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_TOKEN_BUDGET = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_CHUNK_LIMIT  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DECODE_FIRST = 2'd2;

  localparam logic [CNT_W-1:0] TOKEN_BUDGET_RST = 16'd2048;
  localparam logic [CNT_W-1:0] CHUNK_LIMIT_RST  = 16'd512;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [PH_W-1:0]   phase_in;
    logic [CNT_W-1:0]  remaining_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] work_slot;
    logic [CNT_W-1:0]  prefill_count;
    logic              decode_grant;
    logic              work_valid;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_DCNT,
    ST_DMOD,
    ST_DHI,
    ST_DLO,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_START,
    OP_PRE,
    OP_DCNT,
    OP_DMOD,
    OP_DHI,
    OP_DLO,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   idx_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic func_sched;
    logic dec_first;
    logic sched_zero;
    logic budget_zero;
    logic idx_last;
    logic hold;
    logic dcnt_zero;
    logic mod_done;
    logic rank_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- src/token_budget_batch_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// token_budget_batch_scheduler
// Chunked-prefill scheduler: spends a token budget over a table of request
// slots and emits one work beat per slot that receives tokens.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data    | slot write or schedule request
//   out     | out_valid, out_stall, out_data | one work item, last flags end
//   cfg     | cfg_we, cfg_index, cfg_wdata   | one register write
//
// A schedule holds the input from acceptance until its final beat is loaded:
// the table is walked one entry per cycle for prefill, decode count and two
// rotated decode scans, with offset reduction steps (at most 15) before the
// rotated scans; the rotated scans are skipped without decode slots and scans
// end early once the budget is spent.
// Output stalls hold the walk when a new beat meets a full output stage, and
// hold the final beat until the output register frees.
// rst_n is synchronous; it clears the table and the offset and restores the
// register defaults.
// ----------------------------------------------------------------------------
module token_budget_batch_scheduler import tbbs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tbbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tbbs_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- src/tbbs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbbs_ctrl
// Sequencer: walks the slot table through prefill, decode count, offset
// reduction, two rotated decode scans and the final beat.
// ----------------------------------------------------------------------------
module tbbs_ctrl import tbbs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         in_stall
);

  state_t state_r;
  state_t state_nxt;
  state_t dec_exit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.idx_clr = 1'b0;
    in_stall    = 1'b1;
    dec_exit    = sts.dec_first ? ST_PRE : ST_FIN;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (sts.func_sched) begin
            cmd.op = OP_START;
            if (sts.sched_zero) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = sts.dec_first ? ST_DCNT : ST_PRE;
            end
          end else begin
            cmd.op = OP_WRITE;
          end
        end
      end
      ST_PRE: begin
        if (sts.budget_zero) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sts.dec_first ? ST_FIN : ST_DCNT;
        end else begin
          cmd.op = OP_PRE;
          if (!sts.hold && sts.idx_last) begin
            state_nxt = sts.dec_first ? ST_FIN : ST_DCNT;
          end
        end
      end
      ST_DCNT: begin
        cmd.op = OP_DCNT;
        if (sts.idx_last) begin
          state_nxt = ST_DMOD;
        end
      end
      ST_DMOD: begin
        if (sts.dcnt_zero) begin
          state_nxt = dec_exit;
        end else begin
          cmd.op = OP_DMOD;
          if (sts.mod_done) begin
            state_nxt = ST_DHI;
          end
        end
      end
      ST_DHI: begin
        if (sts.budget_zero) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = dec_exit;
        end else begin
          cmd.op = OP_DHI;
          if (!sts.hold && sts.idx_last) begin
            state_nxt = ST_DLO;
          end
        end
      end
      ST_DLO: begin
        if (sts.budget_zero || sts.rank_done) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = dec_exit;
        end else begin
          cmd.op = OP_DLO;
          if (!sts.hold && sts.idx_last) begin
            state_nxt = dec_exit;
          end
        end
      end
      ST_FIN: begin
        cmd.op = OP_FIN;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/tbbs_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tbbs_dp
// Datapath: config registers, slot table, budget, decode counters, offset
// reduction, one pending result and the output register.
// ----------------------------------------------------------------------------
module tbbs_dp import tbbs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire in_item_t          in_data,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts
);

  // slots at or above the index space can never be written, so they stay idle
  localparam int TBL = (SLOTS < SLOT_SPACE) ? SLOTS : SLOT_SPACE;
  localparam int IW  = (TBL > 1) ? $clog2(TBL) : 1;
  localparam int CW  = $clog2(TBL + 1);
  localparam int MW  = (CW > RR_W) ? CW : RR_W;

  logic [PH_W-1:0]  ph_r [TBL];
  logic [CNT_W-1:0] rm_r [TBL];

  logic [CNT_W-1:0] budget_cfg_r;
  logic [CNT_W-1:0] chunk_cfg_r;
  logic             dfirst_r;

  logic [IW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] budget_r, budget_nxt;
  logic [CW-1:0]    dcnt_r, dcnt_nxt;
  logic [CW-1:0]    rank_r, rank_nxt;
  logic [RR_W-1:0]  modr_r, modr_nxt;
  logic [RR_W-1:0]  start_r, start_nxt;
  logic [RR_W-1:0]  rr_r, rr_nxt;
  out_item_t        pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_v_r, out_v_nxt;

  logic [PH_W-1:0]  cur_ph;
  logic [CNT_W-1:0] cur_rm;
  logic             is_pre, is_dec;
  logic [CNT_W-1:0] c1, chunk;
  logic             pre_emit, rank_ge, dec_ok;
  logic             emit, hold, step, idx_last, out_free, out_load, mod_done, wr_ok;
  logic [MW:0]      rem_inc;
  out_item_t        new_it;

  assign cur_ph   = ph_r[idx_r];
  assign cur_rm   = rm_r[idx_r];
  assign is_pre   = (cur_ph == PH_PREFILL);
  assign is_dec   = (cur_ph == PH_DECODE);
  assign c1       = (chunk_cfg_r < cur_rm) ? chunk_cfg_r : cur_rm;
  assign chunk    = (budget_r < c1) ? budget_r : c1;
  assign pre_emit = is_pre && (chunk != '0);
  assign rank_ge  = (MW'(rank_r) >= MW'(start_r));
  assign dec_ok   = is_dec && (budget_r != '0);
  assign idx_last = (idx_r == IW'(TBL - 1));
  assign out_free = !out_v_r || !out_stall;
  assign mod_done = (MW'(modr_r) < MW'(dcnt_r));
  assign rem_inc  = (MW + 1)'(modr_r) + (MW + 1)'(1);
  assign wr_ok    = (32'(in_data.slot) < 32'(SLOTS));

  always_comb begin
    emit = 1'b0;
    unique case (cmd.op)
      OP_PRE:  emit = pre_emit;
      OP_DHI:  emit = dec_ok && rank_ge;
      OP_DLO:  emit = dec_ok && !rank_ge;
      default: emit = 1'b0;
    endcase
  end

  assign hold = emit && pend_v_r && !out_free;
  assign step = ((cmd.op == OP_PRE) || (cmd.op == OP_DCNT) || (cmd.op == OP_DHI) ||
                 (cmd.op == OP_DLO)) && !hold;

  always_comb begin
    new_it.work_slot     = SLOT_W'(idx_r);
    new_it.prefill_count = (cmd.op == OP_PRE) ? chunk : '0;
    new_it.decode_grant  = (cmd.op != OP_PRE);
    new_it.work_valid    = 1'b1;
    new_it.last          = 1'b0;
  end

  always_comb begin
    idx_nxt    = idx_r;
    budget_nxt = budget_r;
    dcnt_nxt   = dcnt_r;
    rank_nxt   = rank_r;
    modr_nxt   = modr_r;
    start_nxt  = start_r;
    rr_nxt     = rr_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_load   = 1'b0;

    unique case (cmd.op)
      OP_START: begin
        budget_nxt = budget_cfg_r;
        idx_nxt    = '0;
        rank_nxt   = '0;
        dcnt_nxt   = '0;
        modr_nxt   = rr_r;
        pend_v_nxt = 1'b0;
      end
      OP_PRE: begin
        if (!hold && pre_emit) begin
          budget_nxt = budget_r - chunk;
        end
      end
      OP_DCNT: begin
        dcnt_nxt = dcnt_r + CW'(is_dec);
      end
      OP_DMOD: begin
        if (mod_done) begin
          start_nxt = modr_r;
          rr_nxt    = (rem_inc == (MW + 1)'(dcnt_r)) ? '0 : rem_inc[RR_W-1:0];
        end else begin
          modr_nxt = modr_r - RR_W'(dcnt_r);
        end
      end
      OP_DHI, OP_DLO: begin
        if (!hold && emit) begin
          budget_nxt = budget_r - CNT_W'(1);
        end
      end
      OP_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt      = '0;
            out_nxt.last = 1'b1;
          end
          pend_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // a new beat pushes the pending one out; the pending one holds back last
    if (emit && !hold) begin
      if (pend_v_r) begin
        out_load = 1'b1;
        out_nxt  = pend_r;
      end
      pend_nxt   = new_it;
      pend_v_nxt = 1'b1;
    end

    if (step) begin
      idx_nxt = idx_last ? '0 : idx_r + IW'(1);
      if ((cmd.op == OP_DHI) || (cmd.op == OP_DLO)) begin
        rank_nxt = idx_last ? '0 : rank_r + CW'(is_dec);
      end
    end

    if (cmd.idx_clr) begin
      idx_nxt  = '0;
      rank_nxt = '0;
    end
  end

  assign out_v_nxt = out_load || (out_v_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_cfg_r <= TOKEN_BUDGET_RST;
      chunk_cfg_r  <= CHUNK_LIMIT_RST;
      dfirst_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOKEN_BUDGET: budget_cfg_r <= cfg_wdata;
        CFG_CHUNK_LIMIT:  chunk_cfg_r  <= cfg_wdata;
        CFG_DECODE_FIRST: dfirst_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL; i++) begin
        ph_r[i] <= PH_IDLE;
        rm_r[i] <= '0;
      end
    end else if ((cmd.op == OP_WRITE) && wr_ok) begin
      ph_r[in_data.slot[IW-1:0]] <= in_data.phase_in;
      rm_r[in_data.slot[IW-1:0]] <= in_data.remaining_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rank_r   <= '0;
      rr_r     <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      rank_r   <= rank_nxt;
      rr_r     <= rr_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    budget_r <= budget_nxt;
    dcnt_r   <= dcnt_nxt;
    modr_r   <= modr_nxt;
    start_r  <= start_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    sts.func_sched  = (in_data.func == FUNC_SCHED);
    sts.dec_first   = dfirst_r;
    sts.sched_zero  = (budget_cfg_r == '0);
    sts.budget_zero = (budget_r == '0);
    sts.idx_last    = idx_last;
    sts.hold        = hold;
    sts.dcnt_zero   = (dcnt_r == '0);
    sts.mod_done    = mod_done;
    sts.rank_done   = rank_ge;
    sts.out_free    = out_free;
  end

endmodule

`default_nettype wire

// ----- verif/schedule_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schedule_checker
// Watches the slot/schedule input channel, the work output channel and the
// register port of the batch scheduler. Keeps its own copy of the slot table,
// round-robin pointer and registers, works out the work beats that each
// accepted schedule request must produce, and compares every accepted work
// beat, field by field, with the oldest one still expected.
// ----------------------------------------------------------------------------
module schedule_checker import tbbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                mismatches,
  output int                pending,
  output int                beats_checked
);

  logic [PH_W-1:0]  phase_tbl   [SLOTS_DEF];
  logic [CNT_W-1:0] prompt_left [SLOTS_DEF];
  logic [RR_W-1:0]  rr_ptr;
  logic [CNT_W-1:0] budget_reg;
  logic [CNT_W-1:0] chunk_reg;
  logic             decode_first_reg;
  out_item_t        expected_work [$];

  function automatic void grant(input int s, input int pre, input bit dec);
    out_item_t w;
    w               = '0;
    w.work_slot     = SLOT_W'(s);
    w.prefill_count = CNT_W'(pre);
    w.decode_grant  = dec;
    w.work_valid    = 1'b1;
    expected_work   = {expected_work, w};
  endfunction

  function automatic void grant_prefill(inout int left);
    int c;
    for (int i = 0; i < SLOTS_DEF && left > 0; i++) begin
      if (phase_tbl[i] == PH_PREFILL) begin
        c = int'(prompt_left[i]);
        if (int'(chunk_reg) < c) c = int'(chunk_reg);
        if (left < c) c = left;
        if (c > 0) begin
          grant(i, c, 1'b0);
          left -= c;
        end
      end
    end
  endfunction

  function automatic void grant_decode(inout int left);
    int ids [SLOTS_DEF];
    int n;
    int start;
    n = 0;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (phase_tbl[i] == PH_DECODE) begin
        ids[n] = i;
        n++;
      end
    end
    if (n == 0) return;
    start = int'(rr_ptr) % n;
    for (int k = 0; k < n && left > 0; k++) begin
      grant(ids[(start + k) % n], 0, 1'b1);
      left--;
    end
    rr_ptr = RR_W'((start + 1) % n);
  endfunction

  function automatic void run_schedule();
    int        left;
    int        n0;
    out_item_t w;
    n0   = expected_work.size();
    left = int'(budget_reg);
    if (left > 0) begin
      if (decode_first_reg) begin
        grant_decode(left);
        grant_prefill(left);
      end else begin
        grant_prefill(left);
        grant_decode(left);
      end
    end
    if (expected_work.size() == n0) begin
      w = '0;
    end else begin
      w = expected_work.pop_back();
    end
    w.last        = 1'b1;
    expected_work = {expected_work, w};
  endfunction

  task automatic flag(input string why, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $time, why);
      $display("  expected slot %0d pre %0d dec %b valid %b last %b", want.work_slot,
               want.prefill_count, want.decode_grant, want.work_valid, want.last);
      $display("  actual   slot %0d pre %0d dec %b valid %b last %b", got.work_slot,
               got.prefill_count, got.decode_grant, got.work_valid, got.last);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        phase_tbl[i]   = PH_IDLE;
        prompt_left[i] = '0;
      end
      rr_ptr           = '0;
      budget_reg       = TOKEN_BUDGET_RST;
      chunk_reg        = CHUNK_LIMIT_RST;
      decode_first_reg = 1'b0;
      expected_work.delete();
      mismatches       = 0;
      beats_checked    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (expected_work.size() == 0) begin
          flag("work beat with nothing expected", '0, out_data);
        end else begin
          want = expected_work.pop_front();
          if (out_data.work_slot !== want.work_slot ||
              out_data.prefill_count !== want.prefill_count ||
              out_data.decode_grant !== want.decode_grant ||
              out_data.work_valid !== want.work_valid ||
              out_data.last !== want.last) begin
            flag("work beat mismatch", want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == FUNC_SCHED) begin
          run_schedule();
        end else begin
          phase_tbl[in_data.slot]   = in_data.phase_in;
          prompt_left[in_data.slot] = in_data.remaining_in;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOKEN_BUDGET: budget_reg       = cfg_wdata;
          CFG_CHUNK_LIMIT:  chunk_reg        = cfg_wdata;
          CFG_DECODE_FIRST: decode_first_reg = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = expected_work.size();
  end

endmodule

// ----- verif/token_budget_batch_scheduler_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_budget_batch_scheduler_test
// Drives slot writes and schedule requests into the scheduler under random
// sender gaps and receiver stalls, retunes budget, chunk limit and priority
// between phases, and forces one long output hold-off to back up the block.
// Work beats are checked by schedule_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module token_budget_batch_scheduler_test;
  import tbbs_pkg::*;

  localparam int                LIMIT      = 600000;
  localparam int                DRAIN      = 120;
  localparam int                HOLD_OFF   = 400;
  localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;
  localparam logic [PH_W-1:0]   PH_STRAY   = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int beats_checked;
  int writes_sent   = 0;
  int scheds_sent   = 0;
  int settings_used = 1;
  int cycles        = 0;
  bit quiet          = 1'b1;
  bit pressing       = 1'b0;
  bit hold_off_req   = 1'b0;
  bit hold_off_taken = 1'b0;

  token_budget_batch_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  schedule_checker sched_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles, %0d work beats still expected", cycles, pending);
        $display("** token_budget_batch_scheduler: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    int r;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        out_stall <= 1'b1;
        n = HOLD_OFF;
      end else if (quiet) begin
        out_stall <= 1'b0;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 4);
        end else if (r < 94) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 40);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send(input in_item_t it);
    int gap;
    int r;
    gap = 0;
    if (!quiet && !pressing) begin
      r = $urandom_range(0, 99);
      if (r >= 90)      gap = $urandom_range(8, 30);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.func == FUNC_SCHED) scheds_sent++;
    else writes_sent++;
  endtask

  task automatic write_slot(input int s, input logic [PH_W-1:0] ph, input int rem);
    in_item_t it;
    it.func         = FUNC_WRITE;
    it.slot         = SLOT_W'(s);
    it.phase_in     = ph;
    it.remaining_in = CNT_W'(rem);
    send(it);
  endtask

  task automatic schedule_once();
    in_item_t it;
    it              = '0;
    it.func         = FUNC_SCHED;
    it.slot         = SLOT_W'($urandom_range(0, 15));
    it.phase_in     = PH_W'($urandom_range(0, 3));
    it.remaining_in = CNT_W'($urandom);
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic retune(input int budget, input int chunk, input bit dfirst, input bit stray);
    drain();
    write_reg(CFG_TOKEN_BUDGET, CFG_DW'(budget));
    write_reg(CFG_CHUNK_LIMIT, CFG_DW'(chunk));
    write_reg(CFG_DECODE_FIRST, CFG_DW'(dfirst));
    if (stray) write_reg(CFG_UNUSED, '0);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int               b;
    int               c;
    int               r;
    int               rem;
    logic [PH_W-1:0]  ph;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: empty table, then a mixed table
    schedule_once();
    write_slot(0, PH_PREFILL, 16'hFFFF);
    write_slot(15, PH_PREFILL, 1);
    write_slot(5, PH_PREFILL, 0);
    write_slot(3, PH_DECODE, 16'h8000);
    write_slot(7, PH_DECODE, 0);
    write_slot(9, PH_STRAY, 100);
    write_slot(12, PH_DECODE, 16'h5555);
    repeat (3) schedule_once();

    // budget of one, decode first: only one decode beat, pointer still moves
    quiet = 1'b0;
    retune(1, 512, 1'b1, 1'b0);
    repeat (2) schedule_once();
    // budget of one, prefill first: decode slots starve, pointer still moves
    retune(1, 512, 1'b0, 1'b0);
    repeat (2) schedule_once();
    retune(0, 512, 1'b0, 1'b0);
    schedule_once();
    retune(65535, 65535, 1'b1, 1'b0);
    schedule_once();
    retune(600, 1, 1'b0, 1'b1);
    write_slot(3, PH_IDLE, 0);
    write_slot(7, PH_IDLE, 0);
    write_slot(12, PH_IDLE, 0);
    schedule_once();
    schedule_once();

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 6))
        0:       b = 0;
        1:       b = 1;
        2:       b = $urandom_range(2, 40);
        3:       b = $urandom_range(300, 3000);
        4:       b = 65535;
        default: b = $urandom_range(1, 65535);
      endcase
      case ($urandom_range(0, 7))
        0:       c = 1;
        1:       c = $urandom_range(2, 64);
        2:       c = 512;
        3:       c = 65535;
        4:       c = 0;
        default: c = $urandom_range(1, 65535);
      endcase
      retune(b, c, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 34; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          r = $urandom_range(0, 9);
          if (r < 3)      ph = PH_IDLE;
          else if (r < 6) ph = PH_PREFILL;
          else if (r < 9) ph = PH_DECODE;
          else            ph = PH_STRAY;
          case ($urandom_range(0, 7))
            0:       rem = 0;
            1:       rem = 16'hFFFF;
            2, 3, 4: rem = $urandom_range(1, 600);
            5:       rem = $urandom_range(1, 8);
            default: rem = $urandom_range(0, 65535);
          endcase
          write_slot($urandom_range(0, 15), ph, rem);
        end else begin
          schedule_once();
        end
      end
    end

    // full table, long output hold-off while requests keep coming
    retune(65535, 100, 1'b0, 1'b0);
    quiet    = 1'b0;
    pressing = 1'b1;
    for (int s = 0; s < 16; s++) begin
      write_slot(s, (s % 2) ? PH_PREFILL : PH_DECODE, $urandom_range(150, 65535));
    end
    hold_off_req = 1'b1;
    repeat (24) schedule_once();
    pressing = 1'b0;

    drain();
    $display("ran %0d slot writes, %0d schedules, %0d register settings, %0d beats checked",
             writes_sent, scheds_sent, settings_used, beats_checked);
    $display("zero and full budgets, unit and full chunks, both orders, a %0d-cycle hold-off",
             HOLD_OFF);
    if (mismatches == 0 && pending == 0) begin
      $display("** token_budget_batch_scheduler: PASSED **");
    end else begin
      $display("%0d mismatches, %0d work beats never arrived", mismatches, pending);
      $display("** token_budget_batch_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
